@@ hw/rtl/hs_pkg.sv @@
// Shared types, control-word layout and microprogram of the heap sorter.
`default_nettype none
package hs_pkg;

	localparam int DATA_W = 32;
	localparam int UPC_W  = 5;

	// Wait condition of a step: the step holds until its channel can move.
	typedef enum logic [1:0] {
		W_NONE,
		W_IN,
		W_OUT
	} wait_sel_t;

	// Jump conditions; when false the step counter advances by one.
	typedef enum logic [3:0] {
		JC_NEVER,
		JC_ALWAYS,
		JC_NOT_CLOSE,
		JC_SHORT,
		JC_I_ZERO,
		JC_KID_GE_LEN,
		JC_LESS,
		JC_EXTRACT,
		JC_NOT_LAST
	} jump_sel_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_POS,
		RD_KID,
		RD_KID1,
		RD_ZERO,
		RD_I
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_CNT_IN,
		WR_POS_MAX,
		WR_POS_HELD,
		WR_ZERO_RD,
		WR_I_HELD
	} wr_sel_t;

	typedef enum logic [2:0] {
		P_NONE,
		P_ROOT_BUILD,
		P_ROOT_EXT,
		P_KID_INIT,
		P_DESCEND
	} pos_op_t;

	typedef enum logic [2:0] {
		I_NONE,
		I_BUILD_INIT,
		I_EXT_INIT,
		I_DEC,
		I_ZERO,
		I_INC
	} idx_op_t;

	typedef enum logic [1:0] {
		C_NONE,
		C_INC,
		C_CLEAR
	} cnt_op_t;

	typedef struct packed {
		wait_sel_t        wait_sel;
		jump_sel_t        jump_sel;
		logic [UPC_W-1:0] target;
		rd_sel_t          rd_sel;
		wr_sel_t          wr_sel;
		logic             held_ld;
		logic             kv_ld;
		pos_op_t          pos_op;
		idx_op_t          idx_op;
		cnt_op_t          cnt_op;
		logic             out_ld;
	} hs_ctrl_t;

	// Datapath flags seen by the sequencer.
	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic close;
		logic short_batch;
		logic i_zero;
		logic kid_ge_len;
		logic less;
		logic extract;
		logic not_last;
	} hs_stat_t;

	// Step addresses that are jump targets.
	localparam logic [UPC_W-1:0] ST_LOAD     = 5'd0;
	localparam logic [UPC_W-1:0] ST_BLOOP    = 5'd2;
	localparam logic [UPC_W-1:0] ST_EINIT    = 5'd4;
	localparam logic [UPC_W-1:0] ST_ELOOP    = 5'd5;
	localparam logic [UPC_W-1:0] ST_SIFT     = 5'd9;
	localparam logic [UPC_W-1:0] ST_SLEVEL   = 5'd11;
	localparam logic [UPC_W-1:0] ST_SEND     = 5'd14;
	localparam logic [UPC_W-1:0] ST_OUT_INIT = 5'd16;
	localparam logic [UPC_W-1:0] ST_OLOOP    = 5'd17;

	localparam hs_ctrl_t CTRL_NOP = '{
		wait_sel: W_NONE, jump_sel: JC_NEVER, target: ST_LOAD,
		rd_sel: RD_NONE, wr_sel: WR_NONE, held_ld: 1'b0, kv_ld: 1'b0,
		pos_op: P_NONE, idx_op: I_NONE, cnt_op: C_NONE, out_ld: 1'b0
	};

	// The microprogram: load, heapify, extract, then stream out.
	function automatic hs_ctrl_t rom_word(input logic [UPC_W-1:0] upc);
		hs_ctrl_t w;
		w = CTRL_NOP;
		case (upc)
			5'd0: begin
				w.wait_sel = W_IN;
				w.wr_sel   = WR_CNT_IN;
				w.cnt_op   = C_INC;
				w.jump_sel = JC_NOT_CLOSE;
				w.target   = ST_LOAD;
			end
			5'd1: begin
				w.idx_op   = I_BUILD_INIT;
				w.jump_sel = JC_SHORT;
				w.target   = ST_OUT_INIT;
			end
			5'd2: begin
				w.jump_sel = JC_I_ZERO;
				w.target   = ST_EINIT;
			end
			5'd3: begin
				w.pos_op   = P_ROOT_BUILD;
				w.idx_op   = I_DEC;
				w.jump_sel = JC_ALWAYS;
				w.target   = ST_SIFT;
			end
			5'd4: begin
				w.idx_op = I_EXT_INIT;
			end
			5'd5: begin
				w.rd_sel   = RD_ZERO;
				w.jump_sel = JC_I_ZERO;
				w.target   = ST_OUT_INIT;
			end
			5'd6: begin
				w.held_ld = 1'b1;
				w.rd_sel  = RD_I;
			end
			5'd7: begin
				w.wr_sel = WR_ZERO_RD;
			end
			5'd8: begin
				w.wr_sel   = WR_I_HELD;
				w.pos_op   = P_ROOT_EXT;
				w.idx_op   = I_DEC;
				w.jump_sel = JC_ALWAYS;
				w.target   = ST_SIFT;
			end
			5'd9: begin
				w.rd_sel = RD_POS;
			end
			5'd10: begin
				w.held_ld = 1'b1;
				w.pos_op  = P_KID_INIT;
			end
			5'd11: begin
				w.rd_sel   = RD_KID;
				w.jump_sel = JC_KID_GE_LEN;
				w.target   = ST_SEND;
			end
			5'd12: begin
				w.rd_sel = RD_KID1;
				w.kv_ld  = 1'b1;
			end
			5'd13: begin
				w.wr_sel   = WR_POS_MAX;
				w.pos_op   = P_DESCEND;
				w.jump_sel = JC_LESS;
				w.target   = ST_SLEVEL;
			end
			5'd14: begin
				w.wr_sel   = WR_POS_HELD;
				w.jump_sel = JC_EXTRACT;
				w.target   = ST_ELOOP;
			end
			5'd15: begin
				w.jump_sel = JC_ALWAYS;
				w.target   = ST_BLOOP;
			end
			5'd16: begin
				w.idx_op = I_ZERO;
			end
			5'd17: begin
				w.rd_sel = RD_I;
			end
			5'd18: begin
				w.wait_sel = W_OUT;
				w.out_ld   = 1'b1;
				w.idx_op   = I_INC;
				w.jump_sel = JC_NOT_LAST;
				w.target   = ST_OLOOP;
			end
			5'd19: begin
				w.cnt_op   = C_CLEAR;
				w.jump_sel = JC_ALWAYS;
				w.target   = ST_LOAD;
			end
			default: begin
				w.jump_sel = JC_ALWAYS;
				w.target   = ST_LOAD;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/hs_seq.sv @@
// Microcode sequencer: step counter, control ROM and jump logic.
`default_nettype none
module hs_seq (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire hs_pkg::hs_stat_t stat,
	output hs_pkg::hs_ctrl_t  ctrl,
	output logic              go
);

	logic [hs_pkg::UPC_W-1:0] upc_q;
	logic                     take_jump;

	assign ctrl = hs_pkg::rom_word(upc_q);

	always_comb begin
		case (ctrl.wait_sel)
			hs_pkg::W_IN:  go = stat.in_valid;
			hs_pkg::W_OUT: go = stat.out_free;
			default:       go = 1'b1;
		endcase
	end

	always_comb begin
		case (ctrl.jump_sel)
			hs_pkg::JC_ALWAYS:     take_jump = 1'b1;
			hs_pkg::JC_NOT_CLOSE:  take_jump = !stat.close;
			hs_pkg::JC_SHORT:      take_jump = stat.short_batch;
			hs_pkg::JC_I_ZERO:     take_jump = stat.i_zero;
			hs_pkg::JC_KID_GE_LEN: take_jump = stat.kid_ge_len;
			hs_pkg::JC_LESS:       take_jump = stat.less;
			hs_pkg::JC_EXTRACT:    take_jump = stat.extract;
			hs_pkg::JC_NOT_LAST:   take_jump = stat.not_last;
			default:               take_jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= hs_pkg::ST_LOAD;
		end else if (go) begin
			if (take_jump) begin
				upc_q <= ctrl.target;
			end else begin
				upc_q <= upc_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/hs_dp.sv @@
// Datapath of the heap sorter: value store, sift registers and output register.
`default_nettype none
module hs_dp #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire hs_pkg::hs_ctrl_t                ctrl,
	input  wire logic                            go,
	output hs_pkg::hs_stat_t                     stat,
	input  wire logic                            in_valid,
	input  wire logic signed [hs_pkg::DATA_W-1:0] sample_value,
	input  wire logic                            batch_end,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [hs_pkg::DATA_W-1:0]     sorted_value,
	output logic                                 final_flag
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int KW = CW + 1;

	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             i_q;
	logic [CW-1:0]             len_q;
	logic [AW-1:0]             pos_q;
	logic [KW-1:0]             kid_q;
	logic                      ext_q;
	logic [hs_pkg::DATA_W-1:0] held_q;
	logic [hs_pkg::DATA_W-1:0] kv_q;
	logic                      out_valid_q;
	logic [hs_pkg::DATA_W-1:0] out_value_q;
	logic                      out_final_q;

	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [hs_pkg::DATA_W-1:0] wr_data;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic [hs_pkg::DATA_W-1:0] rd_data;

	logic [KW-1:0]             kid1;
	logic                      kid1_ok;
	logic                      pick;
	logic                      less;
	logic [KW-1:0]             kid_sel;
	logic [hs_pkg::DATA_W-1:0] max_val;

	hs_ram #(
		.WIDTH(hs_pkg::DATA_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// During a sift level, kv_q holds the left child and rd_data the right one.
	assign kid1    = kid_q + 1'b1;
	assign kid1_ok = kid1 < KW'(len_q);
	assign pick    = kid1_ok && ($signed(kv_q) < $signed(rd_data));
	assign kid_sel = pick ? kid1 : kid_q;
	assign max_val = pick ? rd_data : kv_q;
	assign less    = pick ? ($signed(held_q) < $signed(rd_data))
			: ($signed(held_q) < $signed(kv_q));

	always_comb begin
		rd_en = go;
		case (ctrl.rd_sel)
			hs_pkg::RD_POS:  rd_addr = pos_q;
			hs_pkg::RD_KID:  rd_addr = kid_q[AW-1:0];
			hs_pkg::RD_KID1: rd_addr = kid1[AW-1:0];
			hs_pkg::RD_I:    rd_addr = i_q[AW-1:0];
			hs_pkg::RD_ZERO: rd_addr = '0;
			default: begin
				rd_addr = '0;
				rd_en   = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en = go;
		case (ctrl.wr_sel)
			hs_pkg::WR_CNT_IN: begin
				wr_addr = cnt_q[AW-1:0];
				wr_data = sample_value;
			end
			hs_pkg::WR_POS_MAX: begin
				wr_addr = pos_q;
				wr_data = max_val;
			end
			hs_pkg::WR_POS_HELD: begin
				wr_addr = pos_q;
				wr_data = held_q;
			end
			hs_pkg::WR_ZERO_RD: begin
				wr_addr = '0;
				wr_data = rd_data;
			end
			hs_pkg::WR_I_HELD: begin
				wr_addr = i_q[AW-1:0];
				wr_data = held_q;
			end
			default: begin
				wr_addr = '0;
				wr_data = held_q;
				wr_en   = 1'b0;
			end
		endcase
	end

	always_comb begin
		stat.in_valid    = in_valid;
		stat.out_free    = !out_valid_q || out_ready;
		stat.close       = batch_end || (cnt_q == CW'(MAX_ITEMS - 1));
		stat.short_batch = cnt_q < CW'(2);
		stat.i_zero      = i_q == '0;
		stat.kid_ge_len  = kid_q >= KW'(len_q);
		stat.less        = less;
		stat.extract     = ext_q;
		stat.not_last    = (i_q + 1'b1) != cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				case (ctrl.cnt_op)
					hs_pkg::C_INC:   cnt_q <= cnt_q + 1'b1;
					hs_pkg::C_CLEAR: cnt_q <= '0;
					default:         cnt_q <= cnt_q;
				endcase
			end
			if (go && ctrl.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (ctrl.held_ld) begin
				held_q <= rd_data;
			end
			if (ctrl.kv_ld) begin
				kv_q <= rd_data;
			end
			if (ctrl.out_ld) begin
				out_value_q <= rd_data;
				out_final_q <= (i_q + 1'b1) == cnt_q;
			end
			case (ctrl.pos_op)
				hs_pkg::P_ROOT_BUILD: begin
					pos_q <= AW'(i_q - 1'b1);
					len_q <= cnt_q;
					ext_q <= 1'b0;
				end
				hs_pkg::P_ROOT_EXT: begin
					pos_q <= '0;
					len_q <= i_q;
					ext_q <= 1'b1;
				end
				hs_pkg::P_KID_INIT: begin
					kid_q <= KW'({pos_q, 1'b1});
				end
				hs_pkg::P_DESCEND: begin
					if (less) begin
						pos_q <= kid_sel[AW-1:0];
						kid_q <= {kid_sel[KW-2:0], 1'b1};
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
			case (ctrl.idx_op)
				hs_pkg::I_BUILD_INIT: i_q <= ((cnt_q - 1'b1) >> 1) + 1'b1;
				hs_pkg::I_EXT_INIT:   i_q <= cnt_q - 1'b1;
				hs_pkg::I_DEC:        i_q <= i_q - 1'b1;
				hs_pkg::I_ZERO:       i_q <= '0;
				hs_pkg::I_INC:        i_q <= i_q + 1'b1;
				default:              i_q <= i_q;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign final_flag   = out_final_q;

endmodule
`default_nettype wire

@@ hw/rtl/heap_sorter.sv @@
// Top level of the heap sorter: microcode sequencer driving the sort datapath.
//
// Values arrive on the input channel (in_valid/in_ready, sample_value, batch_end),
// one per transaction, and are stored in arrival order. A batch closes on a
// transaction with batch_end set, or on the one that fills the MAX_ITEMS store.
// The block then heap-sorts the batch in place and streams it out in ascending
// order on the output channel (out_valid/out_ready, sorted_value, final_flag),
// with final_flag set on the last value of the batch.
// Loading accepts one transaction per cycle while in_valid is high. Sorting is
// bounded by the single read port of the store: each sift level reads both
// children in turn, then compares the larger one with the held value. Output
// reads each value from the store before loading it into the output
// register.
// No new input is taken while a batch is being sorted or emitted; the last
// result sits in the output register while loading of the next batch starts.
// A stalled receiver holds the sequencer at its output step without loss.
// Reset clears the loaded count and the output valid flag and returns the
// sequencer to the load step; the store itself is not cleared.
`default_nettype none
module heap_sorter #(
	parameter int MAX_ITEMS = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [hs_pkg::DATA_W-1:0] sample_value,
	input  wire logic                             batch_end,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed [hs_pkg::DATA_W-1:0]      sorted_value,
	output logic                                  final_flag
);

	hs_pkg::hs_ctrl_t ctrl;
	hs_pkg::hs_stat_t stat;
	logic             go;

	hs_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.ctrl  (ctrl),
		.go    (go)
	);

	hs_dp #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.go          (go),
		.stat        (stat),
		.in_valid    (in_valid),
		.sample_value(sample_value),
		.batch_end   (batch_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sorted_value(sorted_value),
		.final_flag  (final_flag)
	);

	// Only the load step waits on the input channel.
	assign in_ready = ctrl.wait_sel == hs_pkg::W_IN;

endmodule
`default_nettype wire
